[src/udpd_pkg.sv]
// Package: shared types and constants of the UDP socket table.
`timescale 1ns / 1ps
package udpd_pkg;
  localparam int unsigned SocketCountDef = 8;
  localparam logic [15:0] UdpHdrBytes = 16'd8;
  localparam logic [15:0] PortSearchBase = 16'd1024;
  localparam logic [15:0] BufSizeReset = 16'd576;

  typedef enum logic [2:0] {
    REQ_ALLOC = 3'd0, REQ_FREE = 3'd1, REQ_BIND_RMT = 3'd2, REQ_UNBIND_RMT = 3'd3,
    REQ_BIND_LCL = 3'd4, REQ_MATCH = 3'd5, REQ_SEND = 3'd6, REQ_NONE = 3'd7
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SEARCH, ST_SCAN, ST_APPLY, ST_OUT
  } state_e;

  typedef struct packed {
    logic        used;
    logic [15:0] lport;
    logic [15:0] rport;
    logic [31:0] raddr;
  } entry_t;

  // Token that travels down the cell row during a scan.
  typedef struct packed {
    logic        active;   // token in flight
    logic        mode;     // 0: port taken check, 1: match
    logic [15:0] lport;
    logic [15:0] rport;
    logic [31:0] raddr;
    logic        hit;      // port found used / match found
    logic [3:0]  hit_idx;
    logic        free_fnd; // lowest unused entry seen
    logic [3:0]  free_idx;
  } token_t;

  // Write command broadcast to every cell.
  typedef struct packed {
    logic        en;
    logic [3:0]  idx;
    entry_t      data;
  } wr_t;
endpackage

[src/udpd_cell.sv]
// One table entry that checks and forwards the scan token.
`timescale 1ns / 1ps
module udpd_cell import udpd_pkg::*; #(
  parameter logic [3:0] Index = 4'd0
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  wr_t    wr_i,
  input  token_t tok_i,
  output token_t tok_o,
  output entry_t ent_o
);
  entry_t ent_q;
  token_t tok_d, tok_q;
  logic   lp_eq, m_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else if (wr_i.en && wr_i.idx == Index) begin
      ent_q <= wr_i.data;
    end
  end

  always_comb begin
    lp_eq = ent_q.used && ent_q.lport == tok_i.lport;
    m_ok  = lp_eq && (ent_q.rport == '0 || ent_q.rport == tok_i.rport) &&
            (ent_q.raddr == '0 || ent_q.raddr == tok_i.raddr);
    tok_d = tok_i;
    if (!tok_i.hit && (tok_i.mode ? m_ok : lp_eq)) begin
      tok_d.hit     = 1'b1;
      tok_d.hit_idx = Index;
    end
    if (!tok_i.free_fnd && !ent_q.used) begin
      tok_d.free_fnd = 1'b1;
      tok_d.free_idx = Index;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;
  assign ent_o = ent_q;
endmodule

[src/udp_socket_demux_table.sv]
// Top level: request sequencer around a row of socket table cells.
//   channel  dir  signals                          transfer
//   s_axis   in   s_axis_tvalid/tready/tdata[95:0] one request
//   m_axis   out  m_axis_tvalid/tready/tdata[87:0] one result
//   cfg      in   cfg_we_i/cfg_wdata_i[15:0]       ip_buffer_size write
// Free, bind remote, unbind, send, unknown requests and a bind local that keeps
// its port: decoded and applied in the APPLY state, then the result is registered.
// Match, given-port alloc and a bind local that changes port scan the cell row;
// the result is registered when the token leaves the last cell.
// Alloc with port 0 repeats the scan for each port tried.
// Reset empties the table at once; ip_buffer_size returns to 576.
// The result holds in its register until taken; no request is taken meanwhile.
`timescale 1ns / 1ps
module udp_socket_demux_table import udpd_pkg::*; #(
  parameter int unsigned SOCKET_COUNT = SocketCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // req_type[2:0], socket_index[6:3], lcl_port[22:7], peer_port[38:23],
  // peer_addr[70:39], peer_addr_given[71], length[87:72], checksum_ok[88]
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // ok[0], result_socket[4:1], res_lcl_port[20:5],
  // res_peer_port[36:21], res_peer_addr[68:37], result_length[84:69]
  output logic [87:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);
  localparam int unsigned IdxW = (SOCKET_COUNT > 1) ? $clog2(SOCKET_COUNT) : 1;

  state_e      state_q, state_d;
  logic [15:0] bufsz_q;
  logic [95:0] req_q;
  logic [15:0] port_q, port_d;
  logic [84:0] res_q, res_d;
  token_t      tok [SOCKET_COUNT+1];
  entry_t      ents [SOCKET_COUNT];
  wr_t         wr;
  token_t      tok_in;

  logic [2:0]  req_type;
  logic [3:0]  sidx;
  logic [15:0] lport, rport, len;
  logic [31:0] rip;
  logic        ip_given, csum_ok, idx_ok;
  entry_t      sel;
  token_t      tend;
  logic [15:0] limit, slen;

  assign req_type = req_q[2:0];
  assign sidx     = req_q[6:3];
  assign lport    = req_q[22:7];
  assign rport    = req_q[38:23];
  assign rip      = req_q[70:39];
  assign ip_given = req_q[71];
  assign len      = req_q[87:72];
  assign csum_ok  = req_q[88];
  assign idx_ok   = {1'b0, sidx} < 5'(SOCKET_COUNT);
  assign sel      = idx_ok ? ents[sidx[IdxW-1:0]] : '0;
  assign tend     = tok[SOCKET_COUNT];

  for (genvar g = 0; g < SOCKET_COUNT; g++) begin : g_cell
    udpd_cell #(.Index(4'(g))) u_cell (
      .clk_i, .rst_ni, .wr_i(wr), .tok_i(tok[g]), .tok_o(tok[g+1]), .ent_o(ents[g])
    );
  end
  assign tok[0] = tok_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      bufsz_q <= BufSizeReset;
      m_axis_tvalid <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) bufsz_q <= cfg_wdata_i;
      if (state_d == ST_OUT && state_q != ST_OUT) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) req_q <= s_axis_tdata;
    port_q <= port_d;
    res_q  <= res_d;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (s_axis_tvalid) state_d = ST_APPLY;
      ST_APPLY: begin
        if (req_type == REQ_ALLOC && lport == '0) state_d = ST_SEARCH;
        else if (req_type == REQ_ALLOC || req_type == REQ_MATCH ||
                 (req_type == REQ_BIND_LCL && idx_ok && sel.lport != lport))
          state_d = ST_SCAN;
        else state_d = ST_OUT;
      end
      ST_SEARCH: if (tend.active && (!tend.hit || port_q == '0)) state_d = ST_OUT;
      ST_SCAN:   if (tend.active) state_d = ST_OUT;
      ST_OUT:    if (m_axis_tready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Outputs, token launch, table writes
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    tok_in = '0;
    tok_in.lport = port_q;
    tok_in.rport = rport;
    tok_in.raddr = rip;
    tok_in.mode  = (req_type == REQ_MATCH);
    port_d = port_q;
    res_d  = res_q;
    wr     = '0;
    wr.idx = sidx;
    wr.data = sel;
    slen  = len;
    limit = (bufsz_q >= UdpHdrBytes) ? bufsz_q - UdpHdrBytes : '0;
    unique case (state_q)
      ST_APPLY: begin
        res_d = '0;
        port_d = (req_type == REQ_ALLOC && lport == '0) ? PortSearchBase + 16'd1 : lport;
        tok_in.active = (state_d == ST_SEARCH || state_d == ST_SCAN);
        tok_in.lport  = port_d;
        if (state_d == ST_OUT && idx_ok) begin
          unique case (req_type)
            REQ_FREE: begin
              wr.en = 1'b1; wr.data = '0; res_d[0] = 1'b1;
            end
            REQ_BIND_RMT: begin
              wr.en = 1'b1; wr.data.rport = rport;
              wr.data.raddr = ip_given ? rip : '0; res_d[0] = 1'b1;
            end
            REQ_UNBIND_RMT: begin
              wr.en = 1'b1; wr.data.rport = '0; wr.data.raddr = '0; res_d[0] = 1'b1;
            end
            REQ_BIND_LCL: res_d[0] = 1'b1;
            REQ_SEND: if (sel.rport != '0) begin
              if (slen > limit) slen = limit;
              res_d = {slen + UdpHdrBytes, sel.raddr, sel.rport, sel.lport, 4'd0, 1'b1};
            end
            default: ;
          endcase
        end
      end
      ST_SEARCH: if (tend.active) begin
        if (tend.hit && port_q != '0) begin
          // try the next port
          port_d = port_q + 16'd1;
          tok_in.active = 1'b1;
          tok_in.lport  = port_d;
        end else if (tend.free_fnd) begin
          wr.en = 1'b1; wr.idx = tend.free_idx;
          wr.data = '{used: 1'b1, lport: port_q, rport: '0, raddr: '0};
          res_d = {16'd0, 32'd0, 16'd0, port_q, tend.free_idx, 1'b1};
        end
      end
      ST_SCAN: if (tend.active) begin
        unique case (req_type)
          REQ_ALLOC: if (!tend.hit && tend.free_fnd) begin
            wr.en = 1'b1; wr.idx = tend.free_idx;
            wr.data = '{used: 1'b1, lport: port_q, rport: '0, raddr: '0};
            res_d = {16'd0, 32'd0, 16'd0, port_q, tend.free_idx, 1'b1};
          end
          REQ_BIND_LCL: if (!tend.hit) begin
            wr.en = 1'b1; wr.data.lport = lport; res_d[0] = 1'b1;
          end
          REQ_MATCH: if (len >= UdpHdrBytes && csum_ok && lport != '0 &&
                         rport != '0 && tend.hit) begin
            wr.en = 1'b1; wr.idx = tend.hit_idx;
            wr.data = '{used: 1'b1, lport: lport, rport: rport, raddr: rip};
            res_d = {len - UdpHdrBytes, 32'd0, 16'd0, 16'd0, tend.hit_idx, 1'b1};
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign m_axis_tdata = {3'd0, res_q};
endmodule

[src/udpd_checker.sv]
// Checker: port-level properties of the socket table, bound to the top level.
`timescale 1ns / 1ps
module udpd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [87:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[84:1] == '0)
    else $error("failed result carries data");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("request taken while result pending");
  a_no_double: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("two requests in flight");
endmodule

bind udp_socket_demux_table udpd_checker u_udpd_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata
);

[bench/tb_udp_socket_demux_table.sv]
// Testbench: socket table requests checked against an in-bench table model.
`timescale 1ns / 1ps
module tb_udp_socket_demux_table;
  import udpd_pkg::*;

  localparam int unsigned NSOCK = 8;
  localparam int unsigned LIMIT = 4000000;

  typedef struct packed {
    logic        csum_ok;
    logic [15:0] len;
    logic        ip_given;
    logic [31:0] rip;
    logic [15:0] rport;
    logic [15:0] lport;
    logic [3:0]  idx;
    req_e        req;
  } req_t;

  typedef struct packed {
    logic [15:0] len;
    logic [31:0] rip;
    logic [15:0] rport;
    logic [15:0] lport;
    logic [3:0]  sock;
    logic        ok;
  } res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  udp_socket_demux_table dut (.*);

  always #2 clk_i = ~clk_i;

  // table model
  logic        t_used [NSOCK];
  logic [15:0] t_lport [NSOCK];
  logic [15:0] t_rport [NSOCK];
  logic [31:0] t_raddr [NSOCK];
  logic [15:0] buf_size = BufSizeReset;

  req_t pending_reqs[$];
  res_t expected_res[$];
  int errors = 0, n_sent = 0, n_got = 0, n_ok = 0, cycles = 0;
  int send_gap = 0, recv_gap = 0;
  bit hold_send = 1'b0;

  function automatic bit port_busy(logic [15:0] p);
    for (int i = 0; i < NSOCK; i++) if (t_used[i] && t_lport[i] == p) return 1'b1;
    return 1'b0;
  endfunction

  function automatic res_t table_step(req_t r);
    res_t o;
    logic [15:0] p, lim, l;
    logic [2:0] ix;
    bit idx_ok;
    o = '0;
    idx_ok = r.idx < NSOCK;
    ix = r.idx[2:0];
    case (r.req)
      REQ_ALLOC: begin
        p = r.lport;
        if (p == 0) begin
          p = PortSearchBase;
          do p = p + 16'd1; while (p != 0 && port_busy(p));
        end else if (port_busy(p)) return o;
        for (int i = 0; i < NSOCK; i++) begin
          if (!t_used[i]) begin
            t_used[i] = 1'b1; t_lport[i] = p; t_rport[i] = '0; t_raddr[i] = '0;
            o.ok = 1'b1; o.sock = 4'(i); o.lport = p;
            return o;
          end
        end
      end
      REQ_FREE: if (idx_ok) begin
        t_used[ix] = '0; t_lport[ix] = '0; t_rport[ix] = '0; t_raddr[ix] = '0;
        o.ok = 1'b1;
      end
      REQ_BIND_RMT: if (idx_ok) begin
        t_rport[ix] = r.rport;
        t_raddr[ix] = r.ip_given ? r.rip : '0;
        o.ok = 1'b1;
      end
      REQ_UNBIND_RMT: if (idx_ok) begin
        t_rport[ix] = '0; t_raddr[ix] = '0; o.ok = 1'b1;
      end
      REQ_BIND_LCL: if (idx_ok) begin
        if (t_lport[ix] != r.lport) begin
          if (port_busy(r.lport)) return o;
          t_lport[ix] = r.lport;
        end
        o.ok = 1'b1;
      end
      REQ_MATCH: begin
        if (r.len < UdpHdrBytes || !r.csum_ok || r.lport == 0 || r.rport == 0) return o;
        for (int i = 0; i < NSOCK; i++) begin
          if (!t_used[i] || t_lport[i] != r.lport) continue;
          if (t_rport[i] != 0 && t_rport[i] != r.rport) continue;
          if (t_raddr[i] != 0 && t_raddr[i] != r.rip) continue;
          t_raddr[i] = r.rip; t_rport[i] = r.rport;
          o.ok = 1'b1; o.sock = 4'(i); o.len = r.len - UdpHdrBytes;
          return o;
        end
      end
      REQ_SEND: if (idx_ok && t_rport[ix] != 0) begin
        lim = (buf_size >= UdpHdrBytes) ? buf_size - UdpHdrBytes : '0;
        l = (r.len > lim) ? lim : r.len;
        o.ok = 1'b1; o.lport = t_lport[ix]; o.rport = t_rport[ix];
        o.rip = t_raddr[ix]; o.len = l + UdpHdrBytes;
      end
      default: ;
    endcase
    return o;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_res.push_back(table_step(req_t'(s_axis_tdata[88:0])));
        n_sent++;
        send_gap = $urandom_range(0, 6);
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (send_gap > 0 || hold_send || pending_reqs.size() == 0) begin
          if (send_gap > 0) send_gap--;
          s_axis_tvalid <= 1'b0;
        end else begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {7'd0, pending_reqs.pop_front()};
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    res_t got, want;
    cycles++;
    if (cycles > LIMIT) begin
      $display("udp_socket_demux_table: mismatch");
      $finish;
    end
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = res_t'(m_axis_tdata[84:0]);
        n_got++;
        if (got.ok) n_ok++;
        if (expected_res.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h", got);
        end else begin
          want = expected_res.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display({"result %0d: exp ok=%b s=%0d lp=%h rp=%h ip=%h len=%h, ",
                        "got ok=%b s=%0d lp=%h rp=%h ip=%h len=%h"},
                       n_got, want.ok, want.sock, want.lport, want.rport, want.rip, want.len,
                       got.ok, got.sock, got.lport, got.rport, got.rip, got.len);
          end
        end
        recv_gap = $urandom_range(0, 6);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else m_axis_tready <= 1'b1;
    end
  end

  function automatic logic [15:0] pick_port();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'd1025 + 16'($urandom_range(0, 3));
      default: return 16'd4000 + 16'($urandom_range(0, 5));
    endcase
  endfunction

  function automatic req_t rand_req();
    req_t r;
    r.req = ($urandom_range(0, 20) == 0) ? REQ_NONE : req_e'(3'($urandom_range(0, 6)));
    r.idx = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(8, 15))
                                        : 4'($urandom_range(0, 7));
    r.lport = pick_port();
    r.rport = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                          : 16'd53 + 16'($urandom_range(0, 2));
    r.rip = ($urandom_range(0, 3) == 0) ? $urandom : 32'h0A000001 + $urandom_range(0, 2);
    if ($urandom_range(0, 9) == 0) r.rip = ($urandom_range(0, 1)) ? '0 : '1;
    r.ip_given = 1'($urandom_range(0, 1));
    r.len = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 700));
    r.csum_ok = ($urandom_range(0, 7) != 0);
    return r;
  endfunction

  task automatic drain(int extra);
    while (pending_reqs.size() != 0 || expected_res.size() != 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_buf(logic [15:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    buf_size = v;
  endtask

  initial begin
    req_t r;
    logic [15:0] sizes[5] = '{16'd8, 16'd65535, 16'd0, 16'd100, 16'd576};
    for (int i = 0; i < NSOCK; i++) begin
      t_used[i] = '0; t_lport[i] = '0; t_rport[i] = '0; t_raddr[i] = '0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: allocs to full, binds, matches, sends, rejects
    r = '0;
    r.req = REQ_ALLOC; r.lport = 0; pending_reqs.push_back(r);
    r.lport = 16'hFFFF; pending_reqs.push_back(r);
    pending_reqs.push_back(r);
    r.lport = 0; repeat (6) pending_reqs.push_back(r);
    r = '0; r.req = REQ_BIND_RMT; r.idx = 0; r.rport = 16'hFFFF; r.rip = '1;
    r.ip_given = 1; pending_reqs.push_back(r);
    r.req = REQ_SEND; r.len = 16'hFFFF; pending_reqs.push_back(r);
    r.req = REQ_MATCH; r.lport = 16'd1025; r.len = 16'd8; r.csum_ok = 1;
    pending_reqs.push_back(r);
    r.len = 16'd7; pending_reqs.push_back(r);
    r.len = 16'd20; r.csum_ok = 0; pending_reqs.push_back(r);
    r.csum_ok = 1; r.rport = 0; pending_reqs.push_back(r);
    r = '0; r.req = REQ_BIND_LCL; r.idx = 1; r.lport = 16'd1025; pending_reqs.push_back(r);
    r.lport = 16'd0; pending_reqs.push_back(r);
    r.req = REQ_UNBIND_RMT; r.idx = 0; pending_reqs.push_back(r);
    r.req = REQ_SEND; pending_reqs.push_back(r);
    r.req = REQ_FREE; r.idx = 15; pending_reqs.push_back(r);
    r.idx = 2; pending_reqs.push_back(r);
    r.req = REQ_NONE; pending_reqs.push_back(r);
    drain(40);
    // random requests at five buffer sizes; in the third, the sender is held, then released
    for (int ph = 0; ph < 5; ph++) begin
      write_buf(sizes[ph]);
      for (int k = 0; k < 380; k++) pending_reqs.push_back(rand_req());
      if (ph == 2) begin
        hold_send = 1'b1;
        repeat (30) @(posedge clk_i);
        hold_send = 1'b0;
      end
      drain(40);
    end
    $display("sent %0d requests, %0d results (%0d ok) over five buffer sizes",
             n_sent, n_got, n_ok);
    if (errors == 0 && expected_res.size() == 0) $display("udp_socket_demux_table: match");
    else $display("udp_socket_demux_table: mismatch");
    $finish;
  end
endmodule
